// ===== hdl/ldfw_pkg.sv =====
// ---------------------------------------------------------------------------
// ldfw_pkg: shared types and constants for the loop output duty block
// Field widths, register indexes, reset values, FSM states and the
// command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package ldfw_pkg;

    // default parameter values
    localparam int COUNT_MAX_DEF  = 127;
    localparam int DUTY_WIDTH_DEF = 16;

    // field widths
    localparam int HUM_W    = 14;
    localparam int FB_W     = 13;
    localparam int PROP_W   = 15;
    localparam int GAIN_W   = 16;
    localparam int PERIOD_W = 16;
    localparam int LIMIT_W  = 7;
    localparam int FLAG_N   = 3;

    // stream and config port widths
    localparam int S_TDATA_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // arithmetic
    localparam int GAIN_SHIFT = 10;
    localparam int FRAC_BITS  = 14;
    localparam int P1_W       = HUM_W + GAIN_W;          // humidity * gain
    localparam int RAW_W      = P1_W - GAIN_SHIFT + 1;   // shifted + min
    localparam int P2_W       = PROP_W + PERIOD_W;       // proportion * period
    localparam int SCALED_W   = P2_W - FRAC_BITS;

    localparam logic [HUM_W-1:0] ZERO_HUMIDITY = HUM_W'(100);

    // flag bit positions
    localparam int FLAG_SENSOR = 0;
    localparam int FLAG_HIGH   = 1;
    localparam int FLAG_LOW    = 2;

    // register reset values
    localparam logic [PROP_W-1:0]   RST_MIN_PROP  = PROP_W'(3277);
    localparam logic [PROP_W-1:0]   RST_MAX_PROP  = PROP_W'(18842);
    localparam logic [GAIN_W-1:0]   RST_GAIN      = GAIN_W'(1594);
    localparam logic [FB_W-1:0]     RST_FB_HIGH   = FB_W'(3450);
    localparam logic [FB_W-1:0]     RST_FB_LOW    = FB_W'(680);
    localparam logic [PERIOD_W-1:0] RST_PERIOD    = PERIOD_W'(40000);
    localparam logic [LIMIT_W-1:0]  RST_LIMIT     = LIMIT_W'(5);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_PROP    = 3'd0,
        REG_MAX_PROP    = 3'd1,
        REG_GAIN        = 3'd2,
        REG_FB_HIGH     = 3'd3,
        REG_FB_LOW      = 3'd4,
        REG_PERIOD      = 3'd5,
        REG_FAULT_LIMIT = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [PROP_W-1:0]   min_prop;
        logic [PROP_W-1:0]   max_prop;
        logic [GAIN_W-1:0]   gain;
        logic [FB_W-1:0]     fb_high;
        logic [FB_W-1:0]     fb_low;
        logic [PERIOD_W-1:0] period;
        logic [LIMIT_W-1:0]  limit;
    } t_cfg;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_CLAMP = 2'd1,
        S_SCALE = 2'd2,
        S_LOAD  = 2'd3
    } t_state;

    typedef struct packed {
        logic load_in;   // capture item and first product
        logic step;      // clamp, override, counters
        logic scale;     // second product
        logic load_out;  // move result into output register
    } t_cmd;

    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
    } t_stat;

endpackage

// ===== hdl/loop_output_duty_with_fault_watch.sv =====
// ---------------------------------------------------------------------------
// loop_output_duty_with_fault_watch: humidity to loop output duty, with faults
// Maps a humidity sample to a clamped Q1.14 proportion and a PWM compare
// value, and tracks sensor-zero, feedback-high and feedback-low faults.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream (i_s_*) takes one sample item at a time; master stream (o_m_*)
//   gives one result item per sample. The config channel (i_cfg_*) writes
//   registers 0..6 by index; it is always ready and unknown indexes are
//   dropped. Write config only while no item is in flight.
//   Sequence: an accepted item goes through accept, clamp, scale and load;
//   it runs through the two registered multipliers one after the other,
//   and the next item is accepted only once the current one has been
//   loaded into the output register.
//   Stall: the output register holds a finished result until taken; the
//   next item is accepted and processed meanwhile and waits in the load step
//   until the output register frees up.
//   Reset (synchronous, active low): registers return to their defaults,
//   fault counters and flags clear, the output register empties and the
//   slave side is ready on the first cycle after reset.
// ---------------------------------------------------------------------------
module loop_output_duty_with_fault_watch #(
    parameter int COUNT_MAX  = ldfw_pkg::COUNT_MAX_DEF,
    parameter int DUTY_WIDTH = ldfw_pkg::DUTY_WIDTH_DEF,
    localparam int M_OUT_W   = DUTY_WIDTH + ldfw_pkg::PROP_W + ldfw_pkg::FLAG_N,
    localparam int M_TDATA_W = ((M_OUT_W + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [13:0] humidity_centi, [26:14] feedback_mv, rest zero
    input  logic [ldfw_pkg::S_TDATA_W-1:0] i_s_tdata,
    // master stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [DW-1:0] duty_count, then proportion_q14 (15), sensor_fault,
    // feedback_high_fault, feedback_low_fault, zero fill
    output logic [M_TDATA_W-1:0]           o_m_tdata,
    // config write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ldfw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ldfw_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import ldfw_pkg::*;

    t_cfg  w_cfg;
    t_cmd  w_cmd;
    t_stat w_stat;

    logic [DUTY_WIDTH-1:0] w_duty;
    logic [PROP_W-1:0]     w_prop;
    logic [FLAG_N-1:0]     w_flags;

    // register file
    ldfw_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // sequencer: accept in idle only; one step per cycle, load waits for output
    ldfw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // arithmetic, fault counters and output register
    ldfw_dp #(
        .COUNT_MAX  (COUNT_MAX),
        .DUTY_WIDTH (DUTY_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .i_cfg   (w_cfg),
        .i_hum   (i_s_tdata[HUM_W-1:0]),
        .i_fb    (i_s_tdata[HUM_W+FB_W-1:HUM_W]),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_duty  (w_duty),
        .o_prop  (w_prop),
        .o_flags (w_flags)
    );

    // pack the result item, lowest field first
    assign o_m_tdata = M_TDATA_W'({w_flags[FLAG_LOW], w_flags[FLAG_HIGH],
                                   w_flags[FLAG_SENSOR], w_prop, w_duty});

    // one item at a time: after an accept the slave side closes
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("item accepted while another is in flight");

    // a result only loads into a free output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> w_stat.out_free)
        else $error("result loaded over an untaken result");

    // an accepted item reaches the load step after the clamp and scale steps
    a_reach_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_in |=> ##2 (w_cmd.load_out || !w_stat.out_free))
        else $error("item did not reach the output load step");

    // reset empties the output and opens the slave side
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && o_s_tready))
        else $error("bad state after reset");

endmodule

// ===== hdl/ldfw_cfg.sv =====
// ---------------------------------------------------------------------------
// ldfw_cfg: configuration register file
// Seven writable registers addressed by index; unknown indexes are dropped.
// ---------------------------------------------------------------------------
module ldfw_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ldfw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ldfw_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output ldfw_pkg::t_cfg                 o_cfg
);
    import ldfw_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_prop <= RST_MIN_PROP;
            r_cfg.max_prop <= RST_MAX_PROP;
            r_cfg.gain     <= RST_GAIN;
            r_cfg.fb_high  <= RST_FB_HIGH;
            r_cfg.fb_low   <= RST_FB_LOW;
            r_cfg.period   <= RST_PERIOD;
            r_cfg.limit    <= RST_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_MIN_PROP:    r_cfg.min_prop <= i_cfg_data[PROP_W-1:0];
                REG_MAX_PROP:    r_cfg.max_prop <= i_cfg_data[PROP_W-1:0];
                REG_GAIN:        r_cfg.gain     <= i_cfg_data[GAIN_W-1:0];
                REG_FB_HIGH:     r_cfg.fb_high  <= i_cfg_data[FB_W-1:0];
                REG_FB_LOW:      r_cfg.fb_low   <= i_cfg_data[FB_W-1:0];
                REG_PERIOD:      r_cfg.period   <= i_cfg_data[PERIOD_W-1:0];
                REG_FAULT_LIMIT: r_cfg.limit    <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== hdl/ldfw_ctrl.sv =====
// ---------------------------------------------------------------------------
// ldfw_ctrl: sequencing state machine
// Walks one item through capture, clamp, scale and output load.
// ---------------------------------------------------------------------------
module ldfw_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  ldfw_pkg::t_stat i_stat,
    output ldfw_pkg::t_cmd  o_cmd
);
    import ldfw_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_s_tvalid) n_state = S_CLAMP;
            S_CLAMP: n_state = S_SCALE;
            S_SCALE: n_state = S_LOAD;
            S_LOAD:  if (i_stat.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_s_tready     = 1'b0;
        o_cmd          = '0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.load_in = i_s_tvalid;
            end
            S_CLAMP: o_cmd.step = 1'b1;
            S_SCALE: o_cmd.scale = 1'b1;
            S_LOAD:  o_cmd.load_out = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

// ===== hdl/ldfw_dp.sv =====
// ---------------------------------------------------------------------------
// ldfw_dp: datapath
// Two registered multiplies, clamp and fault override, fault counters and
// the output register.
// ---------------------------------------------------------------------------
module ldfw_dp #(
    parameter int COUNT_MAX  = ldfw_pkg::COUNT_MAX_DEF,
    parameter int DUTY_WIDTH = ldfw_pkg::DUTY_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ldfw_pkg::t_cmd              i_cmd,
    output ldfw_pkg::t_stat             o_stat,
    input  ldfw_pkg::t_cfg              i_cfg,
    input  logic [ldfw_pkg::HUM_W-1:0]  i_hum,
    input  logic [ldfw_pkg::FB_W-1:0]   i_fb,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [DUTY_WIDTH-1:0]       o_duty,
    output logic [ldfw_pkg::PROP_W-1:0] o_prop,
    output logic [ldfw_pkg::FLAG_N-1:0] o_flags
);
    import ldfw_pkg::*;

    localparam int CW   = $clog2(COUNT_MAX + 1);
    localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int XW   = (DUTY_WIDTH > SCALED_W) ? DUTY_WIDTH : SCALED_W;

    function automatic logic [CW-1:0] f_up(input logic [CW-1:0] c);
        if (c < CW'(COUNT_MAX)) f_up = c + 1'b1;
        else f_up = c;
    endfunction

    function automatic logic [CW-1:0] f_down(input logic [CW-1:0] c);
        if (c != '0) f_down = c - 1'b1;
        else f_down = c;
    endfunction

    logic [HUM_W-1:0]  r_hum;
    logic [FB_W-1:0]   r_fb;
    logic [P1_W-1:0]   r_p1;
    logic [PROP_W-1:0] r_prop;
    logic [P2_W-1:0]   r_p2;
    logic [CW-1:0]     r_cnt_s, r_cnt_h, r_cnt_l;
    logic [CW-1:0]     n_cnt_s, n_cnt_h, n_cnt_l;
    logic [FLAG_N-1:0] r_flags, n_flags;

    logic              r_out_valid;
    logic [DUTY_WIDTH-1:0] r_duty;
    logic [PROP_W-1:0] r_out_prop;
    logic [FLAG_N-1:0] r_out_flags;

    logic [RAW_W-1:0]  w_raw;
    logic [PROP_W-1:0] w_clamped, n_prop;
    logic              w_zero, w_high, w_low;
    logic [XW-1:0]     w_scaled, w_max, w_sat;

    // first product straight off the input item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_hum <= i_hum;
            r_fb  <= i_fb;
            r_p1  <= P1_W'(i_hum) * P1_W'(i_cfg.gain);
        end
    end

    // clamp and fault override
    always_comb begin
        w_raw = RAW_W'(r_p1[P1_W-1:GAIN_SHIFT]) + RAW_W'(i_cfg.min_prop);
        priority if (w_raw > RAW_W'(i_cfg.max_prop)) w_clamped = i_cfg.max_prop;
        else if (w_raw < RAW_W'(i_cfg.min_prop)) w_clamped = i_cfg.min_prop;
        else w_clamped = w_raw[PROP_W-1:0];

        w_zero = r_hum < ZERO_HUMIDITY;
        w_high = r_fb > i_cfg.fb_high;
        w_low  = !w_high && (r_fb < i_cfg.fb_low);

        priority if (w_high) n_prop = i_cfg.min_prop;
        else if (w_low) n_prop = i_cfg.max_prop;
        else n_prop = w_clamped;
    end

    // up/down fault counters
    always_comb begin
        n_flags = r_flags;
        if (w_zero) begin
            n_cnt_s = f_up(r_cnt_s);
            if (CMPW'(n_cnt_s) > CMPW'(i_cfg.limit)) n_flags[FLAG_SENSOR] = 1'b1;
        end else begin
            n_cnt_s = f_down(r_cnt_s);
            if (n_cnt_s == '0) n_flags[FLAG_SENSOR] = 1'b0;
        end

        n_cnt_h = r_cnt_h;
        n_cnt_l = r_cnt_l;
        priority if (w_high) begin
            n_cnt_h = f_up(r_cnt_h);
            if (CMPW'(n_cnt_h) > CMPW'(i_cfg.limit)) n_flags[FLAG_HIGH] = 1'b1;
        end else if (w_low) begin
            n_cnt_l = f_up(r_cnt_l);
            if (CMPW'(n_cnt_l) > CMPW'(i_cfg.limit)) n_flags[FLAG_LOW] = 1'b1;
        end else begin
            n_cnt_h = f_down(r_cnt_h);
            n_cnt_l = f_down(r_cnt_l);
            if (n_cnt_h == '0) n_flags[FLAG_HIGH] = 1'b0;
            if (n_cnt_l == '0) n_flags[FLAG_LOW] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_s <= '0;
            r_cnt_h <= '0;
            r_cnt_l <= '0;
            r_flags <= '0;
        end else if (i_cmd.step) begin
            r_cnt_s <= n_cnt_s;
            r_cnt_h <= n_cnt_h;
            r_cnt_l <= n_cnt_l;
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) r_prop <= n_prop;
        if (i_cmd.scale) r_p2 <= P2_W'(r_prop) * P2_W'(i_cfg.period);
    end

    // drop fraction bits, saturate to the duty width
    always_comb begin
        w_scaled = XW'(r_p2[P2_W-1:FRAC_BITS]);
        w_max    = XW'({DUTY_WIDTH{1'b1}});
        w_sat    = (w_scaled > w_max) ? w_max : w_scaled;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_duty      <= w_sat[DUTY_WIDTH-1:0];
            r_out_prop  <= r_prop;
            r_out_flags <= r_flags;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_ready;
    assign o_valid = r_out_valid;
    assign o_duty  = r_duty;
    assign o_prop  = r_out_prop;
    assign o_flags = r_out_flags;

endmodule

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb: stream-level test of loop_output_duty_with_fault_watch
// Sends humidity/feedback sample items with random bursts and gaps while the
// result side stalls on its own pattern. Every result item is checked field
// by field against a cycle-free model of the clamp, the fault override, the
// duty scaling and the three up/down fault counters. Registers are rewritten
// between phases, the extreme and crossed settings among them.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ldfw_pkg::*;

    localparam int DUTY_W    = DUTY_WIDTH_DEF;
    localparam int CNT_MAX   = COUNT_MAX_DEF;
    localparam int OUT_W     = DUTY_W + PROP_W + FLAG_N;
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int HUM_MAX   = (1 << HUM_W) - 1;
    localparam int FB_MAX    = (1 << FB_W) - 1;
    localparam int PROP_MAX  = (1 << PROP_W) - 1;
    localparam logic [63:0] DUTY_SAT = (64'd1 << DUTY_W) - 1;

    localparam int  RX_HOLD_CYCLES = 80;     // long receiver hold-off
    localparam int  DRAIN_LIMIT    = 20000;  // cycles to wait for stragglers
    localparam int  SETTLE_CYCLES  = 8;      // settle time after a drain
    localparam longint RUN_LIMIT_NS = 10_000_000;

    // one result item, unpacked
    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [PROP_W-1:0] prop;
        logic              sensor;
        logic              fb_high;
        logic              fb_low;
    } loop_result_t;

    // shapes of sample runs the stimulus is built from
    typedef enum int {
        RUN_CALM,
        RUN_SENSOR_ZERO,
        RUN_FB_HIGH,
        RUN_FB_LOW,
        RUN_ZERO_AND_HIGH,
        RUN_NOISE,
        RUN_EDGES
    } run_kind_t;

    // receiver stall styles
    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_BEAT
    } rx_style_t;

    // DUT ports; the inputs driven here are known from time zero
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [S_TDATA_W-1:0]   i_s_tdata = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   o_m_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]   i_cfg_data = '0;

    // model copy of registers and fault state
    t_cfg          cfg_model;
    logic [6:0]    sensor_zero_cnt;
    logic [6:0]    high_fault_cnt;
    logic [6:0]    low_fault_cnt;
    logic [2:0]    fault_flags;

    // results predicted for accepted samples, oldest first
    loop_result_t  pending_outputs[$];

    // bookkeeping
    int mismatch_count  = 0;
    int samples_sent    = 0;
    int outputs_checked = 0;
    int cfg_writes      = 0;
    int settings_loaded = 1;
    int flag_seen[3]    = '{0, 0, 0};

    // sender pacing
    int burst_left    = 0;
    bit steady_sender = 1'b0;

    // receiver hold-off handshake between the test thread and the stall process
    int rx_hold_req  = 0;
    int rx_hold_seen = 0;
    int rx_hold_left = 0;
    int rx_style_left = 0;
    int rx_beat = 0;
    rx_style_t rx_style = RX_ALWAYS;

    loop_output_duty_with_fault_watch dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Model of the block
    // ------------------------------------------------------------------

    // Count a fault tick up, saturating; raise the flag once past the limit.
    function automatic logic [6:0] count_rise(logic [6:0] cnt, int flag_bit);
        if (cnt < CNT_MAX) cnt = cnt + 1'b1;
        if (cnt > cfg_model.limit) fault_flags[flag_bit] = 1'b1;
        return cnt;
    endfunction

    // Count a clean tick down, stopping at zero; drop the flag at zero.
    function automatic logic [6:0] count_fall(logic [6:0] cnt, int flag_bit);
        if (cnt != 0) cnt = cnt - 1'b1;
        if (cnt == 0) fault_flags[flag_bit] = 1'b0;
        return cnt;
    endfunction

    // Advance the fault state by one sample and return the result it gives.
    function automatic loop_result_t loop_output_for(logic [HUM_W-1:0] hum,
                                                     logic [FB_W-1:0]  fb);
        logic [31:0]  level;
        logic [63:0]  scaled;
        loop_result_t r;
        if (hum < ZERO_HUMIDITY) sensor_zero_cnt = count_rise(sensor_zero_cnt, FLAG_SENSOR);
        else                     sensor_zero_cnt = count_fall(sensor_zero_cnt, FLAG_SENSOR);

        // linear map, then clamp; the upper bound wins when bounds cross
        level = ((32'(hum) * 32'(cfg_model.gain)) >> GAIN_SHIFT) + 32'(cfg_model.min_prop);
        if (level > 32'(cfg_model.max_prop))      level = 32'(cfg_model.max_prop);
        else if (level < 32'(cfg_model.min_prop)) level = 32'(cfg_model.min_prop);

        // feedback override; the high test takes priority
        if (fb > cfg_model.fb_high) begin
            high_fault_cnt = count_rise(high_fault_cnt, FLAG_HIGH);
            level = 32'(cfg_model.min_prop);
        end else if (fb < cfg_model.fb_low) begin
            low_fault_cnt = count_rise(low_fault_cnt, FLAG_LOW);
            level = 32'(cfg_model.max_prop);
        end else begin
            high_fault_cnt = count_fall(high_fault_cnt, FLAG_HIGH);
            low_fault_cnt  = count_fall(low_fault_cnt, FLAG_LOW);
        end

        scaled = (64'(level) * 64'(cfg_model.period)) >> FRAC_BITS;
        if (scaled > DUTY_SAT) scaled = DUTY_SAT;

        r.duty    = scaled[DUTY_W-1:0];
        r.prop    = level[PROP_W-1:0];
        r.sensor  = fault_flags[FLAG_SENSOR];
        r.fb_high = fault_flags[FLAG_HIGH];
        r.fb_low  = fault_flags[FLAG_LOW];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Reporting and checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        // keep the log short on a badly broken block, but count everything
        if (mismatch_count < 30) $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    // Compare each accepted result item with the oldest prediction.
    always @(posedge i_clk) begin
        loop_result_t seen;
        loop_result_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen.duty    = o_m_tdata[DUTY_W-1:0];
            seen.prop    = o_m_tdata[DUTY_W +: PROP_W];
            seen.sensor  = o_m_tdata[DUTY_W + PROP_W + FLAG_SENSOR];
            seen.fb_high = o_m_tdata[DUTY_W + PROP_W + FLAG_HIGH];
            seen.fb_low  = o_m_tdata[DUTY_W + PROP_W + FLAG_LOW];
            if (pending_outputs.size() == 0) begin
                report_mismatch($sformatf("result with no sample pending, tdata 0x%0h",
                                          o_m_tdata));
            end else begin
                want = pending_outputs.pop_front();
                if (seen.duty !== want.duty)
                    report_mismatch($sformatf("result %0d duty_count got %0d expected %0d",
                                              outputs_checked, seen.duty, want.duty));
                if (seen.prop !== want.prop)
                    report_mismatch($sformatf("result %0d proportion got %0d expected %0d",
                                              outputs_checked, seen.prop, want.prop));
                if (seen.sensor !== want.sensor)
                    report_mismatch($sformatf("result %0d sensor_fault got %b expected %b",
                                              outputs_checked, seen.sensor, want.sensor));
                if (seen.fb_high !== want.fb_high)
                    report_mismatch($sformatf("result %0d feedback_high got %b expected %b",
                                              outputs_checked, seen.fb_high, want.fb_high));
                if (seen.fb_low !== want.fb_low)
                    report_mismatch($sformatf("result %0d feedback_low got %b expected %b",
                                              outputs_checked, seen.fb_low, want.fb_low));
                if (want.sensor)  flag_seen[FLAG_SENSOR]++;
                if (want.fb_high) flag_seen[FLAG_HIGH]++;
                if (want.fb_low)  flag_seen[FLAG_LOW]++;
                outputs_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: randomly chosen stall styles, plus a
    // long hold-off on request from the test thread.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_hold_req != rx_hold_seen) begin
            rx_hold_seen = rx_hold_req;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            if (rx_style_left == 0) begin
                rx_style      = rx_style_t'($urandom_range(0, 3));
                rx_style_left = $urandom_range(20, 200);
            end
            rx_style_left--;
            rx_beat = (rx_beat == 4) ? 0 : rx_beat + 1;
            case (rx_style)
                RX_ALWAYS: i_m_tready <= 1'b1;
                RX_COIN:   i_m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: i_m_tready <= ($urandom_range(0, 3) == 0);
                default:   i_m_tready <= (rx_beat != 2 && rx_beat != 3);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sender and register writes
    // ------------------------------------------------------------------

    // Offer one sample and hold it until accepted; valid stays high so the
    // next item can follow on the very next cycle.
    task automatic send_sample(logic [HUM_W-1:0] hum, logic [FB_W-1:0] fb);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= S_TDATA_W'({fb, hum});
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_outputs.push_back(loop_output_for(hum, fb));
        samples_sent++;
    endtask

    // Drop valid for a while and put junk on the bus meanwhile.
    task automatic pause_sender(int cycles);
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= $urandom;
        repeat (cycles) @(posedge i_clk);
    endtask

    // End a burst now and then with a random gap.
    task automatic pace_sender();
        if (!steady_sender) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 15);
                pause_sender(($urandom_range(0, 4) == 0) ? $urandom_range(5, 14)
                                                         : $urandom_range(1, 4));
            end
        end
    endtask

    // Hold the sender until every predicted result has been taken, then let
    // the pipeline settle.
    task automatic wait_outputs_drained();
        int guard;
        i_s_tvalid <= 1'b0;
        guard = 0;
        while (pending_outputs.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_outputs.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_outputs.size()));
            pending_outputs.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_DAT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_MIN_PROP:    cfg_model.min_prop = val[PROP_W-1:0];
            REG_MAX_PROP:    cfg_model.max_prop = val[PROP_W-1:0];
            REG_GAIN:        cfg_model.gain     = val[GAIN_W-1:0];
            REG_FB_HIGH:     cfg_model.fb_high  = val[FB_W-1:0];
            REG_FB_LOW:      cfg_model.fb_low   = val[FB_W-1:0];
            REG_PERIOD:      cfg_model.period   = val[PERIOD_W-1:0];
            REG_FAULT_LIMIT: cfg_model.limit    = val[LIMIT_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Write all seven registers back to back; call only with nothing in flight.
    task automatic load_config(t_cfg c);
        write_reg(REG_MIN_PROP,    CFG_DAT_W'(c.min_prop));
        write_reg(REG_MAX_PROP,    CFG_DAT_W'(c.max_prop));
        write_reg(REG_GAIN,        CFG_DAT_W'(c.gain));
        write_reg(REG_FB_HIGH,     CFG_DAT_W'(c.fb_high));
        write_reg(REG_FB_LOW,      CFG_DAT_W'(c.fb_low));
        write_reg(REG_PERIOD,      CFG_DAT_W'(c.period));
        write_reg(REG_FAULT_LIMIT, CFG_DAT_W'(c.limit));
        i_cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    function automatic t_cfg pack_settings(int mn, int mx, int gain, int hi, int lo,
                                           int period, int limit);
        t_cfg c;
        c.min_prop = PROP_W'(mn);
        c.max_prop = PROP_W'(mx);
        c.gain     = GAIN_W'(gain);
        c.fb_high  = FB_W'(hi);
        c.fb_low   = FB_W'(lo);
        c.period   = PERIOD_W'(period);
        c.limit    = LIMIT_W'(limit);
        return c;
    endfunction

    function automatic t_cfg random_settings();
        int mn;
        int hi;
        mn = $urandom_range(0, 16000);
        hi = $urandom_range(2000, FB_MAX);
        return pack_settings(mn, $urandom_range(mn, PROP_MAX), $urandom_range(0, 65535),
                             hi, $urandom_range(0, hi), $urandom_range(1, 65535),
                             $urandom_range(0, 20));
    endfunction

    // ------------------------------------------------------------------
    // Sample value pickers, steered by the current thresholds
    // ------------------------------------------------------------------

    function automatic logic [HUM_W-1:0] hum_zero();
        return HUM_W'($urandom_range(0, 99));
    endfunction

    // mostly in range, now and then above full scale
    function automatic logic [HUM_W-1:0] hum_reading();
        if ($urandom_range(0, 7) == 0) return HUM_W'($urandom_range(10001, HUM_MAX));
        return HUM_W'($urandom_range(100, 10000));
    endfunction

    function automatic logic [FB_W-1:0] fb_in_band();
        if (cfg_model.fb_low <= cfg_model.fb_high)
            return FB_W'($urandom_range(cfg_model.fb_low, cfg_model.fb_high));
        return FB_W'($urandom_range(0, FB_MAX));
    endfunction

    function automatic logic [FB_W-1:0] fb_over_high();
        if (cfg_model.fb_high == FB_MAX) return FB_W'(FB_MAX);
        return FB_W'($urandom_range(cfg_model.fb_high + 1, FB_MAX));
    endfunction

    function automatic logic [FB_W-1:0] fb_under_low();
        if (cfg_model.fb_low == 0) return '0;
        return FB_W'($urandom_range(0, cfg_model.fb_low - 1));
    endfunction

    // Send a run of samples of one shape with random content.
    task automatic drive_run(run_kind_t kind, int len);
        logic [HUM_W-1:0] hum;
        logic [FB_W-1:0]  fb;
        for (int k = 0; k < len; k++) begin
            case (kind)
                RUN_CALM: begin
                    hum = hum_reading();
                    fb  = fb_in_band();
                end
                RUN_SENSOR_ZERO: begin
                    hum = hum_zero();
                    fb  = fb_in_band();
                end
                RUN_FB_HIGH: begin
                    hum = hum_reading();
                    fb  = fb_over_high();
                end
                RUN_FB_LOW: begin
                    hum = hum_reading();
                    fb  = fb_under_low();
                end
                RUN_ZERO_AND_HIGH: begin
                    hum = hum_zero();
                    fb  = fb_over_high();
                end
                RUN_NOISE: begin
                    hum = HUM_W'($urandom);
                    fb  = FB_W'($urandom);
                end
                default: begin
                    // straddle every compare boundary
                    case ($urandom_range(0, 3))
                        0:       hum = HUM_W'(99);
                        1:       hum = HUM_W'(100);
                        2:       hum = '0;
                        default: hum = HUM_W'(HUM_MAX);
                    endcase
                    case ($urandom_range(0, 3))
                        0:       fb = cfg_model.fb_low - 1'b1;
                        1:       fb = cfg_model.fb_low;
                        2:       fb = cfg_model.fb_high;
                        default: fb = cfg_model.fb_high + 1'b1;
                    endcase
                end
            endcase
            send_sample(hum, fb);
            pace_sender();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes and threshold edges at reset settings, then raise and
    // clear the sensor-zero flag.
    task automatic test_directed_edges();
        send_sample(0, 2000);
        send_sample(HUM_W'(HUM_MAX), 2000);
        send_sample(99, 680);
        send_sample(100, 3450);
        send_sample(10000, 3451);
        send_sample(5000, 679);
        send_sample(0, 0);
        send_sample(HUM_W'(HUM_MAX), FB_W'(FB_MAX));
        for (int k = 0; k < 7; k++) send_sample(hum_zero(), fb_in_band());
        for (int k = 0; k < 7; k++) send_sample(hum_reading(), fb_in_band());
        wait_outputs_drained();
    endtask

    // Runs of random shape and length; a few are long enough to saturate.
    task automatic test_random_mix(int n_items);
        int        sent;
        int        len;
        int        pick;
        run_kind_t kind;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 9);
            kind = (pick <= 3) ? RUN_CALM : run_kind_t'(pick - 3);
            len  = ($urandom_range(0, 24) == 0) ? $urandom_range(100, 135)
                                                : $urandom_range(1, 14);
            if (len > n_items - sent) len = n_items - sent;
            steady_sender = ($urandom_range(0, 3) == 0);
            drive_run(kind, len);
            sent += len;
        end
        steady_sender = 1'b0;
        wait_outputs_drained();
    endtask

    // Drive each counter into saturation, then count down with calm samples.
    task automatic test_counter_saturation();
        drive_run(RUN_ZERO_AND_HIGH, 130);
        drive_run(RUN_FB_LOW, 130);
        drive_run(RUN_CALM, 20);
        wait_outputs_drained();
    endtask

    // Hold the receiver off while the sender keeps offering back to back,
    // so the block fills and stalls its input.
    task automatic test_output_holdoff();
        steady_sender = 1'b1;
        rx_hold_req <= rx_hold_req + 1;
        drive_run(RUN_CALM, 12);
        drive_run(RUN_SENSOR_ZERO, 10);
        drive_run(RUN_FB_HIGH, 8);
        steady_sender = 1'b0;
        wait_outputs_drained();
    endtask

    // One setting, one batch of mixed runs.
    task automatic test_with_settings(t_cfg c, int n_items);
        load_config(c);
        test_random_mix(n_items);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        cfg_model = '{min_prop: RST_MIN_PROP, max_prop: RST_MAX_PROP, gain: RST_GAIN,
                      fb_high: RST_FB_HIGH, fb_low: RST_FB_LOW, period: RST_PERIOD,
                      limit: RST_LIMIT};
        sensor_zero_cnt = '0;
        high_fault_cnt  = '0;
        low_fault_cnt   = '0;
        fault_flags     = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings first
        test_directed_edges();
        test_random_mix(250);
        test_counter_saturation();
        test_output_holdoff();

        // widest bounds, steepest gain, thresholds that never trip, limit 0
        test_with_settings(pack_settings(0, PROP_MAX, 65535, FB_MAX, 0, 65535, 0), 120);
        // crossed bounds, overlapping thresholds, limit at the counter top,
        // zero period
        test_with_settings(pack_settings(20000, 5000, 3000, 1500, 4000, 0, CNT_MAX), 120);
        repeat (4) test_with_settings(random_settings(), 80);
        // bounds, gain and high threshold at zero, every feedback value a fault
        test_with_settings(pack_settings(0, 0, 0, 0, FB_MAX, 1, 126), 80);

        $display("Run covered %0d samples, %0d results, %0d register writes over %0d settings.",
                 samples_sent, outputs_checked, cfg_writes, settings_loaded);
        $display("Results with sensor/high/low fault flag set: %0d/%0d/%0d.",
                 flag_seen[FLAG_SENSOR], flag_seen[FLAG_HIGH], flag_seen[FLAG_LOW]);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Stop a hung run.
    initial begin
        #(RUN_LIMIT_NS);
        $display("TIMEOUT: stream stopped moving after %0d samples", samples_sent);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
